>>> design/q6kdq_pkg.sv
// ----------------------------------------------------------------------------
// q6kdq_pkg
// Shared types and constants for the 6-bit group dequantizer.
// ----------------------------------------------------------------------------
package q6kdq_pkg;
	localparam logic [5:0] CodeBias = 6'd32;
	localparam logic [31:0] F32Qnan = 32'h7FC0_0000;
	localparam logic [31:0] F32Inf = 32'h7F80_0000;

	// Per-lane context carried from stage 1 to stage 2.
	typedef struct packed {
		logic        sign;
		logic        zero;
		logic        is_nan;
		logic        is_inf;
		logic [9:0]  mant;
		logic [4:0]  ebase;
	} lane_ctl_t;
endpackage

>>> design/q6k_group_dequantizer_unit.sv
// ----------------------------------------------------------------------------
// q6k_group_dequantizer_unit
// Each accepted item passes the three register stages per lane: stage 1,
// stage 2 and the output register; done rises as the result appears.
// Throughput: one item per cycle; busy stays low since the receiver cannot stall.
// Reset clears only the stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module q6k_group_dequantizer_unit import q6kdq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [15:0]       half_scale,
	input  logic [7:0]        low_bits_a,
	input  logic [7:0]        low_bits_b,
	input  logic [7:0]        high_bits,
	input  logic signed [7:0] sub_scale_0,
	input  logic signed [7:0] sub_scale_1,
	input  logic signed [7:0] sub_scale_2,
	input  logic signed [7:0] sub_scale_3,
	input  logic              row_end,
	output logic              done,
	output logic [31:0]       value_0,
	output logic [31:0]       value_1,
	output logic [31:0]       value_2,
	output logic [31:0]       value_3,
	output logic              row_end_out
);
	// Each lane is a three-stage multiply and normalize pipe; the valid bits and
	// the row-end mark travel alongside, so an item enters every cycle.
	logic [2:0] vld_q;
	logic [2:0] re_q;
	logic       acc;

	assign busy = 1'b0;
	assign acc = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[1:0], acc};
		end
	end

	always_ff @(posedge clk) begin
		re_q <= {re_q[1:0], row_end};
	end

	q6kdq_lane u_l0 (.clk, .en1(acc), .en2(vld_q[0]), .en3(vld_q[1]), .half_scale,
		.code({high_bits[1:0], low_bits_a[3:0]}), .sub_scale(sub_scale_0), .value(value_0));
	q6kdq_lane u_l1 (.clk, .en1(acc), .en2(vld_q[0]), .en3(vld_q[1]), .half_scale,
		.code({high_bits[3:2], low_bits_b[3:0]}), .sub_scale(sub_scale_1), .value(value_1));
	q6kdq_lane u_l2 (.clk, .en1(acc), .en2(vld_q[0]), .en3(vld_q[1]), .half_scale,
		.code({high_bits[5:4], low_bits_a[7:4]}), .sub_scale(sub_scale_2), .value(value_2));
	q6kdq_lane u_l3 (.clk, .en1(acc), .en2(vld_q[0]), .en3(vld_q[1]), .half_scale,
		.code({high_bits[7:6], low_bits_b[7:4]}), .sub_scale(sub_scale_3), .value(value_3));

	assign done = vld_q[2];
	assign row_end_out = re_q[2];
endmodule

>>> design/q6kdq_lane.sv
// ----------------------------------------------------------------------------
// q6kdq_lane
// One lane: decode, multiply, normalize and pack, three register stages.
// ----------------------------------------------------------------------------
module q6kdq_lane import q6kdq_pkg::*; (
	input  logic              clk,
	input  logic              en1,
	input  logic              en2,
	input  logic              en3,
	input  logic [15:0]       half_scale,
	input  logic [5:0]        code,
	input  logic signed [7:0] sub_scale,
	output logic [31:0]       value
);
	logic [5:0]  q_s;
	logic        q_neg;
	logic [5:0]  aq;
	logic [7:0]  asc;
	logic [10:0] sig;
	logic [13:0] sq_s1;
	logic [10:0] sig_s1;
	lane_ctl_t   ctl_s1;
	lane_ctl_t   ctl_s2;
	logic [22:0] p_s2;
	logic [22:0] p_n;
	logic [4:0]  top;
	logic [31:0] res;

	always_comb begin
		q_s = code - CodeBias;
		q_neg = q_s[5];
		aq = q_neg ? (6'd0 - q_s) : q_s;
		asc = sub_scale[7] ? (8'd0 - sub_scale) : sub_scale;
		sig = {(half_scale[14:10] != 5'd0), half_scale[9:0]};
	end

	// Stage 1: magnitudes of the two small factors multiplied.
	always_ff @(posedge clk) begin
		if (en1) begin
			sq_s1 <= 14'(asc) * 14'(aq);
			sig_s1 <= sig;
			// A NaN scale keeps its own sign; everything else takes the product sign.
			ctl_s1.sign <= half_scale[15] ^
				(((half_scale[14:10] == 5'h1F) && (half_scale[9:0] != 10'd0)) ?
				1'b0 : (sub_scale[7] ^ q_neg));
			ctl_s1.zero <= (asc == 8'd0) || (aq == 6'd0);
			ctl_s1.is_nan <= (half_scale[14:10] == 5'h1F) && (half_scale[9:0] != 10'd0);
			ctl_s1.is_inf <= (half_scale[14:10] == 5'h1F) && (half_scale[9:0] == 10'd0);
			ctl_s1.mant <= half_scale[9:0];
			ctl_s1.ebase <= (half_scale[14:10] == 5'd0) ? 5'd1 : half_scale[14:10];
		end
	end

	// Stage 2: full product, exact in 23 bits.
	always_ff @(posedge clk) begin
		if (en2) begin
			p_s2 <= 23'(sig_s1) * 23'(sq_s1);
			ctl_s2 <= ctl_s1;
		end
	end

	// Stage 3: leading-one search and packing.
	always_comb begin
		top = 5'd0;
		for (int i = 0; i < 23; i++) begin
			if (p_s2[i]) top = 5'(i);
		end
		p_n = p_s2 << (5'd22 - top);
		if (ctl_s2.is_nan) begin
			res = {ctl_s2.sign, 31'd0} | F32Qnan | {9'd0, ctl_s2.mant, 13'd0};
		end else if (ctl_s2.is_inf) begin
			res = ctl_s2.zero ? F32Qnan : ({ctl_s2.sign, 31'd0} | F32Inf);
		end else if (p_s2 == 23'd0) begin
			res = {ctl_s2.sign, 31'd0};
		end else begin
			// exponent = top + (e - 25) + 127, with subnormal e taken as 1
			res = {ctl_s2.sign, 8'(8'(top) + 8'(ctl_s2.ebase) + 8'd102), p_n[21:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en3) value <= res;
	end
endmodule

>>> design/q6kdq_checker.sv
// ----------------------------------------------------------------------------
// q6kdq_checker
// Port-level checks on the dequantizer's strobe timing.
// ----------------------------------------------------------------------------
module q6kdq_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done) else $error("item lost");
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 3)) else $error("result invented");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy) else $error("busy raised");
endmodule

bind q6k_group_dequantizer_unit q6kdq_checker u_chk (.clk, .arst_n, .start, .busy, .done);
